[rtl/playlist_first_url_scanner_defines.svh]
// assertion macros shared by the playlist scanner checks
`ifndef PLAYLIST_FIRST_URL_SCANNER_DEFINES_SVH
`define PLAYLIST_FIRST_URL_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on clk and dropped while rst_n is low
`define PFUS_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pfus check failed");

// next-cycle implication
`define PFUS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pfus check failed");

`endif

[rtl/pfus_pkg.sv]
// types, codes and character tables for the playlist scanner
package pfus_pkg;

    localparam int KEY_BITS       = 32;
    localparam int URL_START_BITS = 24;
    localparam int URL_LEN_BITS   = 10;
    localparam logic [URL_LEN_BITS-1:0] URL_LEN_MAX = '1;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // line class codes
    localparam logic [2:0] CLS_UNDECIDED   = 3'd0;
    localparam logic [2:0] CLS_FILE_PREFIX = 3'd1;
    localparam logic [2:0] CLS_FILE_KEY    = 3'd2;
    localparam logic [2:0] CLS_FILE_VALUE  = 3'd3;
    localparam logic [2:0] CLS_HTTP        = 3'd4;
    localparam logic [2:0] CLS_HTTPS       = 3'd5;
    localparam logic [2:0] CLS_BARE        = 3'd6;
    localparam logic [2:0] CLS_OTHER       = 3'd7;

    // prefix lengths
    localparam logic [3:0] FILE_WORD_LEN  = 4'd4;
    localparam logic [3:0] HTTP_S_POS     = 4'd4;
    localparam logic [3:0] HTTP_WORD_LEN  = 4'd7;
    localparam logic [3:0] HTTPS_WORD_LEN = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic                      found;
        logic                      from_entry;
        logic [URL_START_BITS-1:0] url_start;
        logic [URL_LEN_BITS-1:0]   url_length;
        logic [KEY_BITS-1:0]       entry_number;
    } out_beat_t;

    // classified byte handed from the front to the back
    typedef struct packed {
        logic [7:0] low_char;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_eq;
        logic       is_space;
        logic       is_crlf;
        logic       is_zero;
        logic       is_final;
    } token_t;

    function automatic logic [7:0] file_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_F;
            4'd1:    c = CH_I;
            4'd2:    c = CH_L;
            4'd3:    c = CH_E;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] http_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_H;
            4'd1:    c = CH_T;
            4'd2:    c = CH_T;
            4'd3:    c = CH_P;
            4'd4:    c = CH_COLON;
            4'd5:    c = CH_SLASH;
            4'd6:    c = CH_SLASH;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] https_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_H;
            4'd1:    c = CH_T;
            4'd2:    c = CH_T;
            4'd3:    c = CH_P;
            4'd4:    c = CH_S;
            4'd5:    c = CH_COLON;
            4'd6:    c = CH_SLASH;
            4'd7:    c = CH_SLASH;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

[rtl/playlist_first_url_scanner.sv]
// the result beat is registered after the final text beat has passed through the token queue, later if stalled
// throughput: one text beat per cycle while byte_stall is low, set by the line update in the back end
// a four-entry token queue lets the byte side run while the result beat waits to be taken
// reset (rst_n low, asynchronous) clears the queue, all line and selection state, no result held
// top level of the playlist url scanner
module playlist_first_url_scanner #(
    parameter int LINE_BYTES  = 1024,
    parameter int OFFSET_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  pfus_pkg::in_beat_t  byte_beat,
    output logic                result_valid,
    input  logic                result_stall,
    output pfus_pkg::out_beat_t result_beat
);
    import pfus_pkg::*;

    token_t front_tok;
    token_t back_tok;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign byte_stall = q_full;

    pfus_front u_front (
        .beat (byte_beat),
        .tok  (front_tok)
    );

    pfus_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_valid),
        .push_tok  (front_tok),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_tok   (back_tok)
    );

    pfus_back #(
        .LINE_BYTES  (LINE_BYTES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_valid),
        .tok          (back_tok),
        .tok_pop      (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

endmodule

[rtl/pfus_front.sv]
// front end: turns each input byte into a classified token
module pfus_front (
    input  pfus_pkg::in_beat_t beat,
    output pfus_pkg::token_t   tok
);
    import pfus_pkg::*;

    logic [7:0] c;
    logic [7:0] digit_wide;

    assign c          = beat.text_byte;
    assign digit_wide = c - CH_ZERO;

    always_comb
    begin
        tok.low_char = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CH_CASE) : c;
        tok.digit    = digit_wide[3:0];
        tok.is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        tok.is_eq    = (c == CH_EQ);
        tok.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
        tok.is_crlf  = (c == CH_CR) || (c == CH_LF);
        tok.is_zero  = (c == CH_NUL);
        tok.is_final = (c == CH_NUL) || beat.end_of_text;
    end

endmodule

[rtl/pfus_queue.sv]
// short token queue between front and back
module pfus_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pfus_pkg::token_t push_tok,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop,
    output pfus_pkg::token_t pop_tok
);
    import pfus_pkg::*;

    token_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      do_push, do_pop;

    localparam logic [QUEUE_PTR_BITS:0] DEPTH_COUNT = (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_PTR_BITS-1:0] LAST_PTR  = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_PTR_BITS-1:0] PTR_ONE   = QUEUE_PTR_BITS'(1);
    localparam logic [QUEUE_PTR_BITS:0]   COUNT_ONE = (QUEUE_PTR_BITS+1)'(1);

    assign full      = (count_reg == DEPTH_COUNT);
    assign pop_valid = (count_reg != '0);
    assign pop_tok   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + COUNT_ONE;
            2'b01:   count_next = count_reg - COUNT_ONE;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

[rtl/pfus_back.sv]
// back end: line tracking, entry selection and the result register
module pfus_back #(
    parameter int LINE_BYTES  = 1024,
    parameter int OFFSET_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    input  pfus_pkg::token_t    tok,
    output logic                tok_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output pfus_pkg::out_beat_t result_beat
);
    import pfus_pkg::*;

    localparam int LEN_BITS = $clog2(LINE_BYTES);
    localparam logic [LEN_BITS-1:0]    CUT_LEN    = LEN_BITS'(LINE_BYTES - 1);
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] line_start_reg, line_start_next;
    logic [LEN_BITS-1:0]    kept_length_reg, kept_length_next;
    logic                   leading_space_reg, leading_space_next;
    logic [2:0]             line_class_reg, line_class_next;
    logic [3:0]             prefix_position_reg, prefix_position_next;
    logic [KEY_BITS-1:0]    key_value_reg, key_value_next;
    logic [LEN_BITS-1:0]    value_start_reg, value_start_next;
    logic [OFFSET_BITS-1:0] value_abs_reg, value_abs_next;
    logic                   value_seen_reg, value_seen_next;
    logic [LEN_BITS-1:0]    last_nonspace_reg, last_nonspace_next;
    logic                   best_valid_reg, best_valid_next;
    logic [KEY_BITS-1:0]    best_number_reg, best_number_next;
    logic [OFFSET_BITS-1:0] best_start_reg, best_start_next;
    logic [LEN_BITS-1:0]    best_length_reg, best_length_next;
    logic                   bare_valid_reg, bare_valid_next;
    logic [OFFSET_BITS-1:0] bare_start_reg, bare_start_next;
    logic [LEN_BITS-1:0]    bare_length_reg, bare_length_next;
    logic                   res_valid_reg, res_valid_next;
    out_beat_t              res_beat_reg, res_beat_next;

    logic                   slot_free, do_take, do_end, load_result;
    logic [LEN_BITS-1:0]    rel;
    logic [KEY_BITS+3:0]    key_wide;
    logic [KEY_BITS-1:0]    entry_idx;
    logic [LEN_BITS-1:0]    pick_length;
    logic [OFFSET_BITS-1:0] pick_start;

    assign slot_free    = !res_valid_reg || !result_stall;
    assign tok_pop      = tok_valid && (!tok.is_final || slot_free);
    assign do_take      = !tok.is_zero && !tok.is_crlf;
    assign do_end       = tok.is_crlf || tok.is_final;
    assign load_result  = tok_pop && tok.is_final;
    assign result_valid = res_valid_reg;
    assign result_beat  = res_beat_reg;

    always_comb
    begin
        byte_offset_next     = byte_offset_reg;
        line_start_next      = line_start_reg;
        kept_length_next     = kept_length_reg;
        leading_space_next   = leading_space_reg;
        line_class_next      = line_class_reg;
        prefix_position_next = prefix_position_reg;
        key_value_next       = key_value_reg;
        value_start_next     = value_start_reg;
        value_abs_next       = value_abs_reg;
        value_seen_next      = value_seen_reg;
        last_nonspace_next   = last_nonspace_reg;
        best_valid_next      = best_valid_reg;
        best_number_next     = best_number_reg;
        best_start_next      = best_start_reg;
        best_length_next     = best_length_reg;
        bare_valid_next      = bare_valid_reg;
        bare_start_next      = bare_start_reg;
        bare_length_next     = bare_length_reg;
        rel                  = '0;
        key_wide             = '0;
        entry_idx            = '0;
        pick_length          = '0;
        pick_start           = '0;
        res_beat_next        = res_beat_reg;

        // take one text byte into the current line
        if (do_take && !(leading_space_reg && tok.is_space))
        begin
            if (leading_space_reg)
            begin
                leading_space_next = 1'b0;
                line_start_next    = byte_offset_reg;
                kept_length_next   = '0;
            end
            if (kept_length_next < CUT_LEN)
            begin
                rel = kept_length_next;
                case (line_class_reg)
                    CLS_UNDECIDED:
                    begin
                        if (tok.low_char == CH_F)
                        begin
                            line_class_next      = CLS_FILE_PREFIX;
                            prefix_position_next = 4'd1;
                        end
                        else if (tok.low_char == CH_H)
                        begin
                            line_class_next      = CLS_HTTP;
                            prefix_position_next = 4'd1;
                        end
                        else
                        begin
                            line_class_next = CLS_OTHER;
                        end
                    end
                    CLS_FILE_PREFIX:
                    begin
                        if ((prefix_position_reg < FILE_WORD_LEN)
                            && (tok.low_char == file_char(prefix_position_reg)))
                        begin
                            prefix_position_next = prefix_position_reg + 4'd1;
                            if (prefix_position_next == FILE_WORD_LEN)
                            begin
                                line_class_next = CLS_FILE_KEY;
                            end
                        end
                        else
                        begin
                            line_class_next = CLS_OTHER;
                        end
                    end
                    CLS_FILE_KEY:
                    begin
                        if (tok.is_eq)
                        begin
                            line_class_next = CLS_FILE_VALUE;
                        end
                        else if (tok.is_digit)
                        begin
                            // key * 10 + digit, saturating
                            key_wide = ({4'b0, key_value_reg} << 3)
                                     + ({4'b0, key_value_reg} << 1)
                                     + (KEY_BITS+4)'(tok.digit);
                            key_value_next = (key_wide[KEY_BITS+3:KEY_BITS] != 4'd0)
                                           ? KEY_MAX : key_wide[KEY_BITS-1:0];
                        end
                        else
                        begin
                            line_class_next = CLS_OTHER;
                        end
                    end
                    CLS_FILE_VALUE:
                    begin
                        if (!value_seen_reg && !tok.is_space)
                        begin
                            value_seen_next  = 1'b1;
                            value_start_next = rel;
                            value_abs_next   = byte_offset_reg;
                        end
                    end
                    CLS_HTTP:
                    begin
                        if ((prefix_position_reg == HTTP_S_POS) && (tok.low_char == CH_S))
                        begin
                            line_class_next      = CLS_HTTPS;
                            prefix_position_next = HTTP_S_POS + 4'd1;
                        end
                        else if ((prefix_position_reg < HTTP_WORD_LEN)
                                 && (tok.low_char == http_char(prefix_position_reg)))
                        begin
                            prefix_position_next = prefix_position_reg + 4'd1;
                            if (prefix_position_next == HTTP_WORD_LEN)
                            begin
                                line_class_next = CLS_BARE;
                            end
                        end
                        else
                        begin
                            line_class_next = CLS_OTHER;
                        end
                    end
                    CLS_HTTPS:
                    begin
                        if ((prefix_position_reg < HTTPS_WORD_LEN)
                            && (tok.low_char == https_char(prefix_position_reg)))
                        begin
                            prefix_position_next = prefix_position_reg + 4'd1;
                            if (prefix_position_next == HTTPS_WORD_LEN)
                            begin
                                line_class_next = CLS_BARE;
                            end
                        end
                        else
                        begin
                            line_class_next = CLS_OTHER;
                        end
                    end
                    default:
                    begin
                        line_class_next = line_class_reg;
                    end
                endcase
                if (!tok.is_space)
                begin
                    last_nonspace_next = rel + LEN_BITS'(1);
                end
                kept_length_next = rel + LEN_BITS'(1);
            end
        end

        // end of line: update the best entry or the first bare url
        if (do_end && !leading_space_next && (last_nonspace_next != '0))
        begin
            if ((line_class_next == CLS_FILE_VALUE) && value_seen_next
                && (value_start_next < last_nonspace_next))
            begin
                entry_idx = (key_value_next == '0) ? KEY_BITS'(1) : key_value_next;
                if (!best_valid_reg || (entry_idx < best_number_reg))
                begin
                    best_valid_next  = 1'b1;
                    best_number_next = entry_idx;
                    best_start_next  = value_abs_next;
                    best_length_next = last_nonspace_next - value_start_next;
                end
            end
            else if ((line_class_next == CLS_BARE) && !bare_valid_reg)
            begin
                bare_valid_next  = 1'b1;
                bare_start_next  = line_start_next;
                bare_length_next = last_nonspace_next;
            end
        end

        // result from the selection just made
        res_beat_next = '0;
        if (best_valid_next)
        begin
            pick_start                 = best_start_next;
            pick_length                = best_length_next;
            res_beat_next.found        = 1'b1;
            res_beat_next.from_entry   = 1'b1;
            res_beat_next.entry_number = best_number_next;
        end
        else if (bare_valid_next)
        begin
            pick_start          = bare_start_next;
            pick_length         = bare_length_next;
            res_beat_next.found = 1'b1;
        end
        res_beat_next.url_start  = URL_START_BITS'(pick_start);
        res_beat_next.url_length = (32'(pick_length) > 32'(URL_LEN_MAX))
                                 ? URL_LEN_MAX : URL_LEN_BITS'(pick_length);

        if (!tok.is_zero && (byte_offset_reg != OFFSET_MAX))
        begin
            byte_offset_next = byte_offset_reg + OFFSET_BITS'(1);
        end

        if (do_end)
        begin
            kept_length_next     = '0;
            last_nonspace_next   = '0;
            leading_space_next   = 1'b1;
            line_class_next      = CLS_UNDECIDED;
            prefix_position_next = '0;
            key_value_next       = '0;
            value_start_next     = '0;
            value_abs_next       = '0;
            value_seen_next      = 1'b0;
        end

        // text done: back to reset values for the next text
        if (tok.is_final)
        begin
            byte_offset_next = '0;
            line_start_next  = '0;
            best_valid_next  = 1'b0;
            best_number_next = '0;
            best_start_next  = '0;
            best_length_next = '0;
            bare_valid_next  = 1'b0;
            bare_start_next  = '0;
            bare_length_next = '0;
        end
    end

    always_comb
    begin
        if (load_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg     <= '0;
            line_start_reg      <= '0;
            kept_length_reg     <= '0;
            leading_space_reg   <= 1'b1;
            line_class_reg      <= CLS_UNDECIDED;
            prefix_position_reg <= '0;
            key_value_reg       <= '0;
            value_start_reg     <= '0;
            value_abs_reg       <= '0;
            value_seen_reg      <= 1'b0;
            last_nonspace_reg   <= '0;
            best_valid_reg      <= 1'b0;
            best_number_reg     <= '0;
            best_start_reg      <= '0;
            best_length_reg     <= '0;
            bare_valid_reg      <= 1'b0;
            bare_start_reg      <= '0;
            bare_length_reg     <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            if (tok_pop)
            begin
                byte_offset_reg     <= byte_offset_next;
                line_start_reg      <= line_start_next;
                kept_length_reg     <= kept_length_next;
                leading_space_reg   <= leading_space_next;
                line_class_reg      <= line_class_next;
                prefix_position_reg <= prefix_position_next;
                key_value_reg       <= key_value_next;
                value_start_reg     <= value_start_next;
                value_abs_reg       <= value_abs_next;
                value_seen_reg      <= value_seen_next;
                last_nonspace_reg   <= last_nonspace_next;
                best_valid_reg      <= best_valid_next;
                best_number_reg     <= best_number_next;
                best_start_reg      <= best_start_next;
                best_length_reg     <= best_length_next;
                bare_valid_reg      <= bare_valid_next;
                bare_start_reg      <= bare_start_next;
                bare_length_reg     <= bare_length_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            res_beat_reg <= res_beat_next;
        end
    end

endmodule

[rtl/pfus_checker.sv]
// port checks for the playlist url scanner and their bind
`include "playlist_first_url_scanner_defines.svh"

module pfus_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_stall,
    input pfus_pkg::out_beat_t result_beat
);
    import pfus_pkg::*;

    // a stalled result beat stays put
    `PFUS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_beat))

    // nothing found means an all-zero result
    `PFUS_ASSERT_IMPLY(a_empty_zero, result_valid && !result_beat.found, !result_beat.from_entry && (result_beat.url_start == '0) && (result_beat.url_length == '0) && (result_beat.entry_number == '0))

    // an entry has an index of at least one and a non-empty value
    `PFUS_ASSERT_IMPLY(a_entry_shape, result_valid && result_beat.from_entry, result_beat.found && (result_beat.entry_number != '0) && (result_beat.url_length != '0))

    // a bare url line holds at least the http prefix
    `PFUS_ASSERT_IMPLY(a_bare_shape, result_valid && result_beat.found && !result_beat.from_entry, (result_beat.entry_number == '0) && (result_beat.url_length >= URL_LEN_BITS'(HTTP_WORD_LEN)))

endmodule

bind playlist_first_url_scanner pfus_checker u_pfus_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
);
